// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file of the slot allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/msa_pkg.sv -----
// Types and constants of the mark-sweep slot allocator.
package msa_pkg;

  localparam int ACT_W     = 2;
  localparam int SLOT_W    = 10;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = 11;
  localparam int TRIG_W    = 16;
  localparam int CFG_IDX_W = 1;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MARK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SWEEP = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OOM      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_USED = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TRIG = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LATER_TRIG = 1'b1;

  localparam logic [TRIG_W-1:0] FIRST_TRIG_RST = 16'd500;
  localparam logic [TRIG_W-1:0] LATER_TRIG_RST = 16'd100;
  localparam logic [TRIG_W-1:0] ALLOC_MAX      = 16'hFFFF;

  typedef struct packed {
    logic used;
    logic mark;
  } slot_st_t;

  typedef struct packed {
    logic fs_we;
    logic st_we;
  } pool_wen_t;

endpackage

// ----- sv/msa_pool.sv -----
// Free-index stack memory and per-slot used/mark memory, registered reads.
module msa_pool import msa_pkg::*; #(
  parameter int SLOTS = 1024,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic             clk,
  input  pool_wen_t        wen,
  input  logic [IDX_W-1:0] fs_waddr,
  input  logic [IDX_W-1:0] fs_wdata,
  input  logic [IDX_W-1:0] fs_raddr,
  input  logic [IDX_W-1:0] st_waddr,
  input  slot_st_t         st_wdata,
  input  logic [IDX_W-1:0] st_raddr,
  output logic [IDX_W-1:0] fs_rdata,
  output slot_st_t         st_rdata
);

  logic [IDX_W-1:0] free_stack [SLOTS];
  slot_st_t         slot_st    [SLOTS];

  always_ff @(posedge clk) begin
    if (wen.fs_we) begin
      free_stack[fs_waddr] <= fs_wdata;
    end
    fs_rdata <= free_stack[fs_raddr];
  end

  always_ff @(posedge clk) begin
    if (wen.st_we) begin
      slot_st[st_waddr] <= st_wdata;
    end
    st_rdata <= slot_st[st_raddr];
  end

endmodule

// ----- sv/msa_ctrl.sv -----
// Sequencer: fill pass, allocate, mark, sweep walk, and the result register.
module msa_ctrl import msa_pkg::*; #(
  parameter int SLOTS = 1024,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ACT_W-1:0]  in_action,
  input  logic [SLOT_W-1:0] in_target_slot,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SLOT_W-1:0] out_granted_slot,
  output logic [STAT_W-1:0] out_status,
  output logic [CNT_W-1:0]  out_freed_count,
  output logic [CNT_W-1:0]  out_live_count,
  output logic              out_gc_due,
  input  logic [TRIG_W-1:0] first_trig,
  input  logic [TRIG_W-1:0] later_trig,
  output pool_wen_t         wen,
  output logic [IDX_W-1:0]  fs_waddr,
  output logic [IDX_W-1:0]  fs_wdata,
  output logic [IDX_W-1:0]  fs_raddr,
  output logic [IDX_W-1:0]  st_waddr,
  output slot_st_t          st_wdata,
  output logic [IDX_W-1:0]  st_raddr,
  input  logic [IDX_W-1:0]  fs_rdata,
  input  slot_st_t          st_rdata
);

  localparam logic [IDX_W:0]   SLOTS_V = (IDX_W+1)'(SLOTS);
  localparam logic [IDX_W-1:0] LAST_V  = IDX_W'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_FILL, S_IDLE, S_ALLOC, S_MARK, S_SWEEP, S_HOLD
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  fill_r, fill_nxt;
  logic [IDX_W:0]    stack_top_r, stack_top_nxt;
  logic [TRIG_W-1:0] alloc_cnt_r, alloc_cnt_nxt;
  logic              first_done_r, first_done_nxt;
  logic [IDX_W:0]    scan_r, scan_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic [IDX_W:0]    freed_r, freed_nxt;
  logic [IDX_W-1:0]  tgt_r, tgt_nxt;
  logic              tgt_ok_r, tgt_ok_nxt;
  logic [SLOT_W-1:0] hold_granted_r, hold_granted_nxt;
  logic [STAT_W-1:0] hold_status_r, hold_status_nxt;
  logic [CNT_W-1:0]  hold_freed_r, hold_freed_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0] out_granted_r, out_granted_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [CNT_W-1:0]  out_freed_r, out_freed_nxt;
  logic [CNT_W-1:0]  out_live_r, out_live_nxt;
  logic              out_due_r, out_due_nxt;

  logic              out_free, acc, pool_full, tgt_ok, fin, do_free, due;
  logic [IDX_W-1:0]  tgt_addr;
  logic [SLOT_W-1:0] res_granted;
  logic [STAT_W-1:0] res_status;
  logic [CNT_W-1:0]  res_freed;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign acc       = in_valid && !in_stall;
  assign pool_full = (stack_top_r >= SLOTS_V);
  assign tgt_addr  = IDX_W'(in_target_slot);
  assign tgt_ok    = (32'(in_target_slot) < SLOTS);
  assign do_free   = chk_vld_r && st_rdata.used && !st_rdata.mark && (stack_top_r != '0);

  // gc_due on the state as it stands after this item
  assign due = (alloc_cnt_nxt >= later_trig) &&
               (first_done_nxt || (alloc_cnt_nxt >= first_trig));

  assign fs_raddr = stack_top_r[IDX_W-1:0];
  assign st_raddr = (state_r == S_SWEEP) ? scan_r[IDX_W-1:0] : tgt_addr;

  always_comb begin
    state_nxt        = state_r;
    fill_nxt         = fill_r;
    stack_top_nxt    = stack_top_r;
    alloc_cnt_nxt    = alloc_cnt_r;
    first_done_nxt   = first_done_r;
    scan_nxt         = scan_r;
    chk_vld_nxt      = chk_vld_r;
    chk_idx_nxt      = chk_idx_r;
    freed_nxt        = freed_r;
    tgt_nxt          = tgt_r;
    tgt_ok_nxt       = tgt_ok_r;
    hold_granted_nxt = hold_granted_r;
    hold_status_nxt  = hold_status_r;
    hold_freed_nxt   = hold_freed_r;
    wen              = '0;
    fs_waddr         = '0;
    fs_wdata         = '0;
    st_waddr         = '0;
    st_wdata         = '0;
    fin              = 1'b0;
    res_granted      = '0;
    res_status       = STAT_OK;
    res_freed        = '0;

    case (state_r)
      S_FILL: begin
        wen.fs_we = 1'b1;
        wen.st_we = 1'b1;
        fs_waddr  = fill_r;
        fs_wdata  = fill_r;
        st_waddr  = fill_r;
        if (fill_r == LAST_V) begin
          state_nxt = S_IDLE;
        end else begin
          fill_nxt = fill_r + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (acc) begin
          hold_granted_nxt = '0;
          hold_status_nxt  = STAT_OK;
          hold_freed_nxt   = '0;
          case (in_action)
            ACT_ALLOC: begin
              if (pool_full) begin
                hold_status_nxt = STAT_OOM;
                state_nxt       = S_HOLD;
              end else begin
                state_nxt = S_ALLOC;
              end
            end
            ACT_MARK: begin
              tgt_nxt    = tgt_addr;
              tgt_ok_nxt = tgt_ok;
              state_nxt  = S_MARK;
            end
            ACT_SWEEP: begin
              scan_nxt    = '0;
              chk_vld_nxt = 1'b0;
              freed_nxt   = '0;
              state_nxt   = S_SWEEP;
            end
            default: begin
              state_nxt = S_HOLD;
            end
          endcase
        end
      end
      S_ALLOC: begin
        // free slots never carry a mark, so the mark bit is written clear
        wen.st_we     = 1'b1;
        st_waddr      = fs_rdata;
        st_wdata.used = 1'b1;
        stack_top_nxt = stack_top_r + (IDX_W+1)'(1);
        if (alloc_cnt_r != ALLOC_MAX) begin
          alloc_cnt_nxt = alloc_cnt_r + TRIG_W'(1);
        end
        fin         = 1'b1;
        res_granted = SLOT_W'(fs_rdata);
      end
      S_MARK: begin
        fin = 1'b1;
        if (tgt_ok_r && st_rdata.used) begin
          wen.st_we     = 1'b1;
          st_waddr      = tgt_r;
          st_wdata.used = 1'b1;
          st_wdata.mark = 1'b1;
        end else begin
          res_status = STAT_NOT_USED;
        end
      end
      S_SWEEP: begin
        // read slot k+1 while slot k is written back
        if (scan_r != SLOTS_V) begin
          scan_nxt    = scan_r + (IDX_W+1)'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_r[IDX_W-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (chk_vld_r) begin
          wen.st_we     = 1'b1;
          st_waddr      = chk_idx_r;
          st_wdata.used = st_rdata.used && !do_free;
          if (do_free) begin
            wen.fs_we     = 1'b1;
            fs_waddr      = stack_top_r[IDX_W-1:0] - IDX_W'(1);
            fs_wdata      = chk_idx_r;
            stack_top_nxt = stack_top_r - (IDX_W+1)'(1);
            freed_nxt     = freed_r + (IDX_W+1)'(1);
          end
        end
        if ((scan_r == SLOTS_V) && !chk_vld_r) begin
          fin            = 1'b1;
          res_freed      = CNT_W'(freed_r);
          alloc_cnt_nxt  = '0;
          first_done_nxt = 1'b1;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        state_nxt = S_IDLE;
      end else begin
        hold_granted_nxt = res_granted;
        hold_status_nxt  = res_status;
        hold_freed_nxt   = res_freed;
        state_nxt        = S_HOLD;
      end
    end
  end

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_granted_nxt = out_granted_r;
    out_status_nxt  = out_status_r;
    out_freed_nxt   = out_freed_r;
    out_live_nxt    = out_live_r;
    out_due_nxt     = out_due_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (fin && out_free) begin
      out_valid_nxt   = 1'b1;
      out_granted_nxt = res_granted;
      out_status_nxt  = res_status;
      out_freed_nxt   = res_freed;
      out_live_nxt    = CNT_W'(stack_top_nxt);
      out_due_nxt     = due;
    end else if ((state_r == S_HOLD) && out_free) begin
      out_valid_nxt   = 1'b1;
      out_granted_nxt = hold_granted_r;
      out_status_nxt  = hold_status_r;
      out_freed_nxt   = hold_freed_r;
      out_live_nxt    = CNT_W'(stack_top_nxt);
      out_due_nxt     = due;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_FILL;
      fill_r       <= '0;
      stack_top_r  <= '0;
      alloc_cnt_r  <= '0;
      first_done_r <= 1'b0;
      scan_r       <= '0;
      chk_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      stack_top_r  <= stack_top_nxt;
      alloc_cnt_r  <= alloc_cnt_nxt;
      first_done_r <= first_done_nxt;
      scan_r       <= scan_nxt;
      chk_vld_r    <= chk_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    chk_idx_r      <= chk_idx_nxt;
    freed_r        <= freed_nxt;
    tgt_r          <= tgt_nxt;
    tgt_ok_r       <= tgt_ok_nxt;
    hold_granted_r <= hold_granted_nxt;
    hold_status_r  <= hold_status_nxt;
    hold_freed_r   <= hold_freed_nxt;
    out_granted_r  <= out_granted_nxt;
    out_status_r   <= out_status_nxt;
    out_freed_r    <= out_freed_nxt;
    out_live_r     <= out_live_nxt;
    out_due_r      <= out_due_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_granted_r;
  assign out_status       = out_status_r;
  assign out_freed_count  = out_freed_r;
  assign out_live_count   = out_live_r;
  assign out_gc_due       = out_due_r;

endmodule

// ----- sv/mark_sweep_slot_allocator_top.sv -----
// Top level of the mark-sweep slot allocator: trigger registers, sequencer and pool.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_action, in_target_slot
//   out_     output     out_valid/out_stall granted_slot, status, freed_count,
//                                           live_count, gc_due
//   cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// After reset a fill pass loads the free stack and clears the slot state; in_stall
// stays high meanwhile, cfg writes are taken throughout.
// Allocate and mark: accept, then a state that works on the registered memory read.
// Sweep walks one slot a cycle through the slot-state memory port.
// Out-of-memory and unused action codes go from accept straight to the hold state.
// A waiting result blocks the next item: in_stall stays high in the hold state until the result can leave.
module mark_sweep_slot_allocator_top import msa_pkg::*; #(
  parameter int SLOTS = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ACT_W-1:0]     in_action,
  input  logic [SLOT_W-1:0]    in_target_slot,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SLOT_W-1:0]    out_granted_slot,
  output logic [STAT_W-1:0]    out_status,
  output logic [CNT_W-1:0]     out_freed_count,
  output logic [CNT_W-1:0]     out_live_count,
  output logic                 out_gc_due,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TRIG_W-1:0]    cfg_wdata
);

  localparam int IDX_W = $clog2(SLOTS);

  logic [TRIG_W-1:0] first_trig_r, first_trig_nxt;
  logic [TRIG_W-1:0] later_trig_r, later_trig_nxt;

  pool_wen_t        wen;
  logic [IDX_W-1:0] fs_waddr, fs_wdata, fs_raddr, fs_rdata;
  logic [IDX_W-1:0] st_waddr, st_raddr;
  slot_st_t         st_wdata, st_rdata;

  always_comb begin
    first_trig_nxt = first_trig_r;
    later_trig_nxt = later_trig_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FIRST_TRIG: first_trig_nxt = cfg_wdata;
        CFG_LATER_TRIG: later_trig_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_trig_r <= FIRST_TRIG_RST;
      later_trig_r <= LATER_TRIG_RST;
    end else begin
      first_trig_r <= first_trig_nxt;
      later_trig_r <= later_trig_nxt;
    end
  end

  msa_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_target_slot   (in_target_slot),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status),
    .out_freed_count  (out_freed_count),
    .out_live_count   (out_live_count),
    .out_gc_due       (out_gc_due),
    .first_trig       (first_trig_r),
    .later_trig       (later_trig_r),
    .wen              (wen),
    .fs_waddr         (fs_waddr),
    .fs_wdata         (fs_wdata),
    .fs_raddr         (fs_raddr),
    .st_waddr         (st_waddr),
    .st_wdata         (st_wdata),
    .st_raddr         (st_raddr),
    .fs_rdata         (fs_rdata),
    .st_rdata         (st_rdata)
  );

  msa_pool #(.SLOTS(SLOTS)) u_pool (
    .clk      (clk),
    .wen      (wen),
    .fs_waddr (fs_waddr),
    .fs_wdata (fs_wdata),
    .fs_raddr (fs_raddr),
    .st_waddr (st_waddr),
    .st_wdata (st_wdata),
    .st_raddr (st_raddr),
    .fs_rdata (fs_rdata),
    .st_rdata (st_rdata)
  );

endmodule

// ----- sv/msa_checker.sv -----
// Port-level checks of the slot allocator, bound to the top level.
`include "assert_macros.svh"

module msa_checker import msa_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [SLOT_W-1:0] out_granted_slot,
  input logic [STAT_W-1:0] out_status,
  input logic [CNT_W-1:0]  out_freed_count,
  input logic [CNT_W-1:0]  out_live_count,
  input logic              out_gc_due
);

  // a stalled item holds
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_granted_slot) && $stable(out_status) && $stable(out_freed_count) && $stable(out_live_count) && $stable(out_gc_due), "stalled result changed")

  // one item at a time: busy right after an accept
  `ASSERT_NEXT(a_busy_after_acc, in_valid && !in_stall, in_stall, "item accepted while busy")

  `ASSERT_IMP(a_oom_fields, out_valid && (out_status == STAT_OOM), (out_granted_slot == '0) && (out_freed_count == '0), "out of memory result carries data")

  `ASSERT_IMP(a_sweep_fields, out_valid && (out_freed_count != '0), (out_granted_slot == '0) && (out_status == STAT_OK), "sweep result carries grant or error")

  `ASSERT_IMP(a_mark_err_fields, out_valid && (out_status == STAT_NOT_USED), (out_granted_slot == '0) && (out_freed_count == '0), "failed mark carries data")

endmodule

bind mark_sweep_slot_allocator_top msa_checker u_msa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_granted_slot (out_granted_slot),
  .out_status       (out_status),
  .out_freed_count  (out_freed_count),
  .out_live_count   (out_live_count),
  .out_gc_due       (out_gc_due)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the mark-sweep slot allocator: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

typedef struct packed {
  logic [msa_pkg::SLOT_W-1:0] granted;
  logic [msa_pkg::STAT_W-1:0] status;
  logic [msa_pkg::CNT_W-1:0]  freed;
  logic [msa_pkg::CNT_W-1:0]  live;
  logic                       due;
} alloc_result_t;

class alloc_scoreboard #(int NSLOTS = 1024);
  logic [msa_pkg::SLOT_W-1:0] free_idx [NSLOTS];
  bit                         in_use [NSLOTS];
  bit                         marked [NSLOTS];
  int unsigned                top;
  logic [msa_pkg::TRIG_W-1:0] allocs;
  bit                         swept_once;
  logic [msa_pkg::TRIG_W-1:0] first_trig;
  logic [msa_pkg::TRIG_W-1:0] later_trig;
  alloc_result_t              replies_due [$];
  int unsigned n_errors, n_in, n_out, n_oom, n_bad_mark, n_sweeps, n_due;

  function new();
    for (int i = 0; i < NSLOTS; i++) begin
      free_idx[i] = msa_pkg::SLOT_W'(i);
      in_use[i]   = 1'b0;
      marked[i]   = 1'b0;
    end
    top        = 0;
    allocs     = '0;
    swept_once = 1'b0;
    first_trig = msa_pkg::FIRST_TRIG_RST;
    later_trig = msa_pkg::LATER_TRIG_RST;
  endfunction

  function void set_trigger(logic [msa_pkg::CFG_IDX_W-1:0] idx,
                            logic [msa_pkg::TRIG_W-1:0] val);
    case (idx)
      msa_pkg::CFG_FIRST_TRIG: first_trig = val;
      msa_pkg::CFG_LATER_TRIG: later_trig = val;
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return replies_due.size();
  endfunction

  // random slot currently in use, or any slot when the pool is empty
  function logic [msa_pkg::SLOT_W-1:0] pick_used();
    int unsigned k;
    k = $urandom_range(0, NSLOTS - 1);
    for (int i = 0; i < NSLOTS; i++)
      if (in_use[(k + i) % NSLOTS]) return msa_pkg::SLOT_W'((k + i) % NSLOTS);
    return msa_pkg::SLOT_W'(k);
  endfunction

  // accepted request: work out the allocator's reply and queue it
  function void note_request(logic [msa_pkg::ACT_W-1:0] act,
                             logic [msa_pkg::SLOT_W-1:0] tgt);
    alloc_result_t r;
    r = '0;
    n_in++;
    case (act)
      msa_pkg::ACT_ALLOC: begin
        if (top >= NSLOTS) begin
          r.status = msa_pkg::STAT_OOM;
          n_oom++;
        end else begin
          r.granted = free_idx[top];
          in_use[free_idx[top]] = 1'b1;
          top++;
          if (allocs != msa_pkg::ALLOC_MAX) allocs++;
        end
      end
      msa_pkg::ACT_MARK: begin
        if (tgt >= NSLOTS || !in_use[tgt]) begin
          r.status = msa_pkg::STAT_NOT_USED;
          n_bad_mark++;
        end else begin
          marked[tgt] = 1'b1;
        end
      end
      msa_pkg::ACT_SWEEP: begin
        // ascending scan, so the highest freed index ends up on top
        for (int i = 0; i < NSLOTS; i++) begin
          if (in_use[i] && !marked[i] && top > 0) begin
            in_use[i] = 1'b0;
            top--;
            free_idx[top] = msa_pkg::SLOT_W'(i);
            r.freed++;
          end
        end
        for (int i = 0; i < NSLOTS; i++) marked[i] = 1'b0;
        allocs     = '0;
        swept_once = 1'b1;
        n_sweeps++;
      end
      default: ;
    endcase
    r.live = msa_pkg::CNT_W'(top);
    r.due  = (allocs >= later_trig) && (swept_once || allocs >= first_trig);
    if (r.due) n_due++;
    replies_due.push_back(r);
  endfunction

  function void check_reply(alloc_result_t got);
    alloc_result_t exp;
    n_out++;
    if (replies_due.size() == 0) begin
      $error("result item with nothing expected: granted_slot %0d status %0d",
             got.granted, got.status);
      n_errors++;
      return;
    end
    exp = replies_due.pop_front();
    if (got.granted !== exp.granted) begin
      $error("granted_slot: expected %0d, got %0d", exp.granted, got.granted);
      n_errors++;
    end
    if (got.status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, got.status);
      n_errors++;
    end
    if (got.freed !== exp.freed) begin
      $error("freed_count: expected %0d, got %0d", exp.freed, got.freed);
      n_errors++;
    end
    if (got.live !== exp.live) begin
      $error("live_count: expected %0d, got %0d", exp.live, got.live);
      n_errors++;
    end
    if (got.due !== exp.due) begin
      $error("gc_due: expected %0d, got %0d", exp.due, got.due);
      n_errors++;
    end
  endfunction
endclass

module tb_top;
  import msa_pkg::*;

  localparam int          SLOTS       = 1024;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned PHASE_ITEMS = 175;
  localparam logic [ACT_W-1:0] ACT_RSVD = 2'd3;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic [ACT_W-1:0]     in_action      = ACT_ALLOC;
  logic [SLOT_W-1:0]    in_target_slot = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic [SLOT_W-1:0]    out_granted_slot;
  logic [STAT_W-1:0]    out_status;
  logic [CNT_W-1:0]     out_freed_count;
  logic [CNT_W-1:0]     out_live_count;
  logic                 out_gc_due;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = CFG_FIRST_TRIG;
  logic [TRIG_W-1:0]    cfg_wdata      = '0;

  alloc_scoreboard #(SLOTS) pool;
  int unsigned burst_left = 0;

  mark_sweep_slot_allocator_top #(.SLOTS(SLOTS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_target_slot   (in_target_slot),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_granted_slot (out_granted_slot),
    .out_status       (out_status),
    .out_freed_count  (out_freed_count),
    .out_live_count   (out_live_count),
    .out_gc_due       (out_gc_due),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      pool.check_reply(alloc_result_t'{out_granted_slot, out_status, out_freed_count,
                                       out_live_count, out_gc_due});
  end

  // result side: stall patterns in stretches, plus one long hold-off
  initial begin : receiver
    int unsigned mode, span, tick;
    bit          hold_done;
    hold_done = 1'b0;
    tick      = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && pool.n_in >= 400) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(32, 256);
      repeat (span) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ((tick % 5) >= 3);
          default: out_stall <= ($urandom_range(0, 99) < 75);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(logic [ACT_W-1:0] act, logic [SLOT_W-1:0] tgt);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_action      <= act;
    in_target_slot <= tgt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pool.note_request(act, tgt);
  endtask

  task automatic set_triggers(logic [TRIG_W-1:0] first_val, logic [TRIG_W-1:0] later_val);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FIRST_TRIG;
    cfg_wdata <= first_val;
    @(posedge clk);
    pool.set_trigger(CFG_FIRST_TRIG, first_val);
    cfg_index <= CFG_LATER_TRIG;
    cfg_wdata <= later_val;
    @(posedge clk);
    pool.set_trigger(CFG_LATER_TRIG, later_val);
    cfg_we <= 1'b0;
  endtask

  // stop offering and wait for every outstanding result item
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pool.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_item(int unsigned alloc_pct, int unsigned sweep_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < alloc_pct)                  send_item(ACT_ALLOC, SLOT_W'($urandom));
    else if (r < alloc_pct + sweep_pct) send_item(ACT_SWEEP, SLOT_W'($urandom));
    else if (r < 94)                    send_item(ACT_MARK, pool.pick_used());
    else if (r < 98)                    send_item(ACT_MARK, SLOT_W'($urandom));
    else                                send_item(ACT_RSVD, SLOT_W'($urandom));
  endtask

  initial begin : stimulus
    int unsigned oom_base;
    pool = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // writes are taken during the clearing pass after reset
    set_triggers(16'd3, 16'd2);

    send_item(ACT_MARK, 10'd0);          // nothing in use yet
    repeat (4) send_item(ACT_ALLOC, 10'h3FF);
    send_item(ACT_MARK, 10'd1);
    send_item(ACT_MARK, 10'd1);          // already marked
    send_item(ACT_MARK, 10'd3);
    send_item(ACT_MARK, 10'h3FF);        // top index, free
    send_item(ACT_RSVD, 10'h155);
    send_item(ACT_SWEEP, 10'h2AA);
    repeat (2) send_item(ACT_ALLOC, 10'd0); // highest freed index comes back first
    send_item(ACT_MARK, 10'd2);
    send_item(ACT_SWEEP, 10'd0);
    send_item(ACT_SWEEP, 10'd0);         // frees slot 2, leaving the pool empty
    send_item(ACT_ALLOC, 10'd0);
    drain();

    // fill the pool to the brim, run into out-of-memory, then collect
    set_triggers(16'hFFFF, 16'd300);
    oom_base = pool.n_oom;
    while (pool.top < SLOTS || pool.n_oom < oom_base + 8)
      random_item(78, 0);
    send_item(ACT_SWEEP, SLOT_W'($urandom));
    drain();

    set_triggers(16'd1, 16'hFFFF);
    repeat (PHASE_ITEMS) random_item(50, 4);
    drain();

    set_triggers(16'd0, 16'd0);          // zero triggers: always due
    repeat (PHASE_ITEMS) random_item(50, 4);
    drain();

    set_triggers(TRIG_W'($urandom_range(1, 64)), TRIG_W'($urandom_range(1, 64)));
    repeat (PHASE_ITEMS) random_item(55, 4);
    drain();
    repeat (SLOTS + 16) @(posedge clk);

    $display("%0d items in, %0d result items checked, %0d mismatches.",
             pool.n_in, pool.n_out, pool.n_errors);
    $display("Covered %0d sweeps, %0d out-of-memory, %0d marks of free slots, %0d gc_due.",
             pool.n_sweeps, pool.n_oom, pool.n_bad_mark, pool.n_due);
    if (pool.n_errors == 0 && pool.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
